/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the distance queue.
// No dependencies; pulled in by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/dqk_pkg.sv */
// Package for the distance queue: widths, command and status codes, types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dqk_pkg;

  localparam int CAPACITY = 256;
  localparam int COORD_W  = 16;
  localparam int TAKE_W   = 9;
  localparam int DIST_W   = 18;
  localparam int ROOT_W   = 16;
  localparam int SQ_W     = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > TAKE_W) ? CNT_W : TAKE_W;
  localparam int SUM_W    = DIST_W + CNT_W;
  localparam int DIV_CW   = $clog2(SUM_W + 1);
  localparam int ROOT_CW  = $clog2(ROOT_W + 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EXCEEDS = 2'd1,
    ST_ZERO    = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_ZERO   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [TAKE_W-1:0]   take;
    logic [DIST_W-1:0]   distance;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ,
    F_ROOT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INS_CHK,
    B_INS_CMP,
    B_SUM_RD,
    B_SUM_ACC,
    B_MV_RD,
    B_MV_WR,
    B_DIV
  } back_state_t;

endpackage

/* hdl/dqk_front.sv */
// Front end: accepts items, computes point distance, classifies queries.
// Depends on dqk_pkg; feeds dqk_queue.
`timescale 1ns / 1ps

module dqk_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [dqk_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [dqk_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [dqk_pkg::COORD_W-1:0]  in_coord_z,
  input  logic [dqk_pkg::TAKE_W-1:0]          in_take_count,
  input  logic                                q_full,
  output logic                                q_push,
  output dqk_pkg::cmd_t                       q_cmd
);

  dqk_pkg::front_state_t state_r, state_nxt;
  logic                               op_r, op_nxt;
  logic [dqk_pkg::TAKE_W-1:0]         take_r, take_nxt;
  logic signed [dqk_pkg::COORD_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [1:0]                         sq_idx_r, sq_idx_nxt;
  logic [dqk_pkg::SQ_W-1:0]           acc_r, acc_nxt;
  logic [dqk_pkg::ROOT_W-1:0]         root_r, root_nxt;
  logic [dqk_pkg::ROOT_W+1:0]         rem_r, rem_nxt;
  logic [dqk_pkg::ROOT_CW-1:0]        cnt_r, cnt_nxt;

  logic signed [dqk_pkg::COORD_W-1:0]   sel;
  logic signed [2*dqk_pkg::COORD_W-1:0] prod;
  logic [dqk_pkg::ROOT_W+3:0]           rem_t;
  logic [dqk_pkg::ROOT_W+3:0]           trial;

  // Square one coordinate per cycle
  always_comb begin
    unique case (sq_idx_r)
      2'd0:    sel = x_r;
      2'd1:    sel = y_r;
      default: sel = z_r;
    endcase
    prod = sel * sel;
  end

  // One result bit of the square root per step
  assign rem_t = {rem_r, acc_r[dqk_pkg::SQ_W-1 -: 2]};
  assign trial = (dqk_pkg::ROOT_W+4)'({root_r, 2'b01});

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    take_nxt   = take_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    sq_idx_nxt = sq_idx_r;
    acc_nxt    = acc_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    q_push     = 1'b0;
    busy       = (state_r != dqk_pkg::F_IDLE);
    q_cmd.take = take_r;
    q_cmd.distance = dqk_pkg::DIST_W'(root_r);
    if (!op_r) begin
      q_cmd.kind = dqk_pkg::CMD_INSERT;
    end else if (take_r == '0) begin
      q_cmd.kind = dqk_pkg::CMD_ZERO;
    end else begin
      q_cmd.kind = dqk_pkg::CMD_QUERY;
    end
    unique case (state_r)
      dqk_pkg::F_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          take_nxt   = in_take_count;
          x_nxt      = in_coord_x;
          y_nxt      = in_coord_y;
          z_nxt      = in_coord_z;
          sq_idx_nxt = 2'd0;
          acc_nxt    = '0;
          state_nxt  = in_op ? dqk_pkg::F_PUSH : dqk_pkg::F_SQ;
        end
      end
      dqk_pkg::F_SQ: begin
        acc_nxt    = acc_r + dqk_pkg::SQ_W'(prod);
        sq_idx_nxt = sq_idx_r + 2'd1;
        if (sq_idx_r == 2'd2) begin
          root_nxt  = '0;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = dqk_pkg::F_ROOT;
        end
      end
      dqk_pkg::F_ROOT: begin
        acc_nxt = {acc_r[dqk_pkg::SQ_W-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt  = (dqk_pkg::ROOT_W+2)'(rem_t - trial);
          root_nxt = {root_r[dqk_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = (dqk_pkg::ROOT_W+2)'(rem_t);
          root_nxt = {root_r[dqk_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == dqk_pkg::ROOT_CW'(dqk_pkg::ROOT_W - 1)) begin
          state_nxt = dqk_pkg::F_PUSH;
        end
      end
      dqk_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = dqk_pkg::F_IDLE;
        end
      end
      default: state_nxt = dqk_pkg::F_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqk_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    take_r   <= take_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    sq_idx_r <= sq_idx_nxt;
    acc_r    <= acc_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

/* hdl/dqk_queue.sv */
// Two-entry command queue between the front end and the store sequencer.
// Depends on dqk_pkg for the command type.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqk_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dqk_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dqk_pkg::cmd_t head
);

  dqk_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ASSERT_IMPL(a_q_no_overflow, clk, rst_n, full, !push)
  `ASSERT_NEXT(a_q_count_track, clk, rst_n, push && !pop && !full, !empty)

endmodule

/* hdl/dqk_back.sv */
// Store sequencer: sorted insertion, k-smallest removal, mean by division.
// Depends on dqk_pkg; pops commands from dqk_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqk_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  dqk_pkg::cmd_t                q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic [dqk_pkg::DIST_W-1:0]   out_mean_distance,
  output logic [1:0]                   out_status
);

  logic [dqk_pkg::DIST_W-1:0] mem [dqk_pkg::CAPACITY];
  logic [dqk_pkg::DIST_W-1:0] rd_data_r;

  dqk_pkg::back_state_t       state_r, state_nxt;
  logic [dqk_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic [dqk_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [dqk_pkg::TAKE_W-1:0] k_r, k_nxt;
  logic [dqk_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [dqk_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [dqk_pkg::TAKE_W-1:0] rem_r, rem_nxt;
  logic [dqk_pkg::DIV_CW-1:0] dcnt_r, dcnt_nxt;
  logic                       ov_r, ov_nxt;
  logic [dqk_pkg::DIST_W-1:0] omean_r, omean_nxt;
  dqk_pkg::status_t           ost_r, ost_nxt;

  logic                       we, re;
  logic [dqk_pkg::ADDR_W-1:0] waddr, raddr;
  logic [dqk_pkg::DIST_W-1:0] wdata;
  logic [dqk_pkg::TAKE_W:0]   rem_t;
  logic [dqk_pkg::CNT_W-1:0]  idx_inc;

  assign rem_t   = {rem_r, sum_r[dqk_pkg::SUM_W-1]};
  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    dist_nxt  = dist_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    ov_nxt    = 1'b0;
    omean_nxt = '0;
    ost_nxt   = dqk_pkg::ST_OK;
    q_pop     = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = idx_r[dqk_pkg::ADDR_W-1:0];
    raddr     = idx_r[dqk_pkg::ADDR_W-1:0];
    wdata     = rd_data_r;
    unique case (state_r)
      // Take the next command and classify against the fill level
      dqk_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          k_nxt    = q_head.take;
          dist_nxt = q_head.distance;
          case (q_head.kind)
            dqk_pkg::CMD_INSERT: begin
              if (held_r == dqk_pkg::CNT_W'(dqk_pkg::CAPACITY)) begin
                ov_nxt  = 1'b1;
                ost_nxt = dqk_pkg::ST_FULL;
              end else begin
                idx_nxt   = held_r;
                state_nxt = dqk_pkg::B_INS_CHK;
              end
            end
            dqk_pkg::CMD_QUERY: begin
              if (dqk_pkg::CMP_W'(q_head.take) > dqk_pkg::CMP_W'(held_r)) begin
                ov_nxt  = 1'b1;
                ost_nxt = dqk_pkg::ST_EXCEEDS;
              end else begin
                idx_nxt   = '0;
                sum_nxt   = '0;
                state_nxt = dqk_pkg::B_SUM_RD;
              end
            end
            default: begin
              ov_nxt  = 1'b1;
              ost_nxt = dqk_pkg::ST_ZERO;
            end
          endcase
        end
      end
      // Insert: look at the entry below the hole
      dqk_pkg::B_INS_CHK: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          wdata     = dist_r;
          held_nxt  = held_r + 1'b1;
          state_nxt = dqk_pkg::B_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = dqk_pkg::ADDR_W'(idx_r - 1'b1);
          state_nxt = dqk_pkg::B_INS_CMP;
        end
      end
      // Insert: shift the larger entry up, or drop the new one in
      dqk_pkg::B_INS_CMP: begin
        we = 1'b1;
        if (rd_data_r > dist_r) begin
          wdata     = rd_data_r;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = dqk_pkg::B_INS_CHK;
        end else begin
          wdata     = dist_r;
          held_nxt  = held_r + 1'b1;
          state_nxt = dqk_pkg::B_IDLE;
        end
      end
      // Query: read the next of the k smallest
      dqk_pkg::B_SUM_RD: begin
        re        = 1'b1;
        state_nxt = dqk_pkg::B_SUM_ACC;
      end
      dqk_pkg::B_SUM_ACC: begin
        sum_nxt = sum_r + dqk_pkg::SUM_W'(rd_data_r);
        idx_nxt = idx_inc;
        if (dqk_pkg::CMP_W'(idx_inc) == dqk_pkg::CMP_W'(k_r)) begin
          state_nxt = dqk_pkg::B_MV_RD;
        end else begin
          state_nxt = dqk_pkg::B_SUM_RD;
        end
      end
      // Query: move the remaining entries down by k
      dqk_pkg::B_MV_RD: begin
        if (idx_r == held_r) begin
          held_nxt  = held_r - dqk_pkg::CNT_W'(k_r);
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = dqk_pkg::B_DIV;
        end else begin
          re        = 1'b1;
          state_nxt = dqk_pkg::B_MV_WR;
        end
      end
      dqk_pkg::B_MV_WR: begin
        we        = 1'b1;
        waddr     = dqk_pkg::ADDR_W'(idx_r - dqk_pkg::CNT_W'(k_r));
        idx_nxt   = idx_inc;
        state_nxt = dqk_pkg::B_MV_RD;
      end
      // Restoring division, one quotient bit per cycle
      dqk_pkg::B_DIV: begin
        if (rem_t >= (dqk_pkg::TAKE_W+1)'(k_r)) begin
          rem_nxt = dqk_pkg::TAKE_W'(rem_t - (dqk_pkg::TAKE_W+1)'(k_r));
          sum_nxt = {sum_r[dqk_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = dqk_pkg::TAKE_W'(rem_t);
          sum_nxt = {sum_r[dqk_pkg::SUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == dqk_pkg::DIV_CW'(dqk_pkg::SUM_W - 1)) begin
          ov_nxt    = 1'b1;
          omean_nxt = sum_nxt[dqk_pkg::DIST_W-1:0];
          ost_nxt   = dqk_pkg::ST_OK;
          state_nxt = dqk_pkg::B_IDLE;
        end
      end
      default: state_nxt = dqk_pkg::B_IDLE;
    endcase
  end

  // Hold control state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqk_pkg::B_IDLE;
      held_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    dist_r  <= dist_nxt;
    sum_r   <= sum_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    omean_r <= omean_nxt;
    ost_r   <= ost_nxt;
  end

  // Sorted store: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_valid         = ov_r;
  assign out_mean_distance = omean_r;
  assign out_status        = ost_r;

  `ASSERT_IMPL(a_held_bound, clk, rst_n, 1'b1,
               held_r <= dqk_pkg::CNT_W'(dqk_pkg::CAPACITY))
  `ASSERT_IMPL(a_err_zero_mean, clk, rst_n, ov_r && ost_r != dqk_pkg::ST_OK, omean_r == '0)
  `ASSERT_NEXT(a_div_remainder, clk, rst_n, state_r == dqk_pkg::B_DIV, rem_r < k_r)

endmodule

/* hdl/distance_queue_kmin_average_top.sv */
// Top level of the distance queue: front end, command queue, store sequencer.
// Depends on dqk_pkg, dqk_front, dqk_queue and dqk_back.
`timescale 1ns / 1ps

// Bounded min-priority queue of 3D point distances. An insert (in_op = 0)
// computes sqrt(x^2+y^2+z^2) in Q18.0, truncated, and files it in a sorted
// store of 256 entries; it gives no result unless the store is full (status
// 3). A query (in_op = 1) removes the in_take_count smallest distances and
// returns their truncated mean with status 0, or status 2 for a count of
// zero and 1 for a count above the number held. Drive start with the item
// while busy is low. Results appear on out_* for one cycle under out_valid
// and cannot be held off, in item order. The front end squares the three
// coordinates of an insert on one multiplier and takes 16 root steps; a
// two-entry queue decouples it from the store sequencer. An insert moves
// each larger entry up by a read and a write, then writes the new one; a
// query reads and sums the k smallest, moves the rest down, then divides.
module distance_queue_kmin_average_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [dqk_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [dqk_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [dqk_pkg::COORD_W-1:0]  in_coord_z,
  input  logic [dqk_pkg::TAKE_W-1:0]          in_take_count,
  output logic                                out_valid,
  output logic [dqk_pkg::DIST_W-1:0]          out_mean_distance,
  output logic [1:0]                          out_status
);

  logic          q_push, q_full, q_pop, q_empty;
  dqk_pkg::cmd_t q_cmd, q_head;

  dqk_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_take_count (in_take_count),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  dqk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  dqk_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_mean_distance (out_mean_distance),
    .out_status        (out_status)
  );

endmodule

/* test/distance_queue_kmin_average_top_tb.sv */
// Testbench for the distance queue: directed and random inserts and queries.
// Depends on dqk_pkg and distance_queue_kmin_average_top; predicts each result.
`timescale 1ns / 1ps

module distance_queue_kmin_average_top_tb;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct {
    logic                               op;
    logic signed [dqk_pkg::COORD_W-1:0] x;
    logic signed [dqk_pkg::COORD_W-1:0] y;
    logic signed [dqk_pkg::COORD_W-1:0] z;
    logic [dqk_pkg::TAKE_W-1:0]         take;
  } item_t;

  typedef struct {
    logic [dqk_pkg::DIST_W-1:0] mean;
    dqk_pkg::status_t           status;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic signed [dqk_pkg::COORD_W-1:0] in_coord_x = '0;
  logic signed [dqk_pkg::COORD_W-1:0] in_coord_y = '0;
  logic signed [dqk_pkg::COORD_W-1:0] in_coord_z = '0;
  logic [dqk_pkg::TAKE_W-1:0] in_take_count = '0;
  logic out_valid;
  logic [dqk_pkg::DIST_W-1:0] out_mean_distance;
  logic [1:0] out_status;

  item_t   pending_items[$];
  result_t expected_results[$];
  logic [dqk_pkg::DIST_W-1:0] model_dists[$];  // ascending distances held
  int  mismatch_count = 0;
  bit  calm_stretch = 1'b0;
  int  model_depth = 0;               // depth seen by the stimulus generator

  distance_queue_kmin_average_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z), .in_take_count(in_take_count),
    .out_valid(out_valid), .out_mean_distance(out_mean_distance),
    .out_status(out_status)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Truncating square root, bit by bit
  function automatic logic [dqk_pkg::DIST_W-1:0] point_root(input logic [33:0] sq);
    logic [33:0] rem;
    logic [33:0] root;
    logic [33:0] bitv;
    rem = sq;
    root = '0;
    bitv = 34'h1 << 32;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[dqk_pkg::DIST_W-1:0];
  endfunction

  // Apply one item to the predicted store and queue its result, if any
  task automatic predict_item(input item_t it);
    logic [33:0] sq;
    logic [dqk_pkg::DIST_W-1:0] d;
    logic [dqk_pkg::DIST_W+dqk_pkg::CNT_W:0] total;
    result_t r;
    int pos;
    int k;
    if (it.op == OP_INSERT) begin
      if (model_dists.size() >= dqk_pkg::CAPACITY) begin
        r.mean = '0;
        r.status = dqk_pkg::ST_FULL;
        expected_results.push_back(r);
      end else begin
        sq = 34'(it.x * it.x) + 34'(it.y * it.y) + 34'(it.z * it.z);
        d = point_root(sq);
        pos = model_dists.size();
        while (pos > 0 && model_dists[pos-1] > d) pos--;
        model_dists.insert(pos, d);
      end
    end else begin
      k = it.take;
      r.mean = '0;
      if (k == 0) begin
        r.status = dqk_pkg::ST_ZERO;
      end else if (k > model_dists.size()) begin
        r.status = dqk_pkg::ST_EXCEEDS;
      end else begin
        total = '0;
        repeat (k) total += model_dists.pop_front();
        r.mean = dqk_pkg::DIST_W'(total / k);
        r.status = dqk_pkg::ST_OK;
      end
      expected_results.push_back(r);
    end
  endtask

  function automatic item_t make_insert(input int x, input int y, input int z);
    item_t it;
    it.op = OP_INSERT;
    it.x = dqk_pkg::COORD_W'(x);
    it.y = dqk_pkg::COORD_W'(y);
    it.z = dqk_pkg::COORD_W'(z);
    it.take = dqk_pkg::TAKE_W'($urandom);
    return it;
  endfunction

  function automatic item_t make_query(input int k);
    item_t it;
    it.op = OP_QUERY;
    it.x = dqk_pkg::COORD_W'($urandom);
    it.y = dqk_pkg::COORD_W'($urandom);
    it.z = dqk_pkg::COORD_W'($urandom);
    it.take = dqk_pkg::TAKE_W'(k);
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    pending_items.push_back(it);
    if (it.op == OP_INSERT) begin
      if (model_depth < dqk_pkg::CAPACITY) model_depth++;
    end else if (it.take != 0 && it.take <= model_depth) begin
      model_depth -= it.take;
    end
  endtask

  // Drive items from the pending queue; idle at random outside the calm stretch
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_item(pending_items.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 &&
            (calm_stretch || $urandom_range(99) >= 13)) begin
          start <= 1'b1;
          in_op <= pending_items[0].op;
          in_coord_x <= pending_items[0].x;
          in_coord_y <= pending_items[0].y;
          in_coord_z <= pending_items[0].z;
          in_take_count <= pending_items[0].take;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result");
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_mean_distance !== want.mean)
          report_mismatch($sformatf("mean %0d, want %0d", out_mean_distance, want.mean));
      end
    end
  end

  // Stimulus: directed cases, then mostly valid random traffic
  initial begin
    int k;
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    queue_item(make_query(0));
    queue_item(make_query(1));
    queue_item(make_insert(0, 0, 0));
    queue_item(make_insert(-32768, -32768, -32768));
    queue_item(make_insert(32767, 32767, 32767));
    queue_item(make_insert(-32768, 0, 0));
    queue_item(make_insert(4096, 0, 0));
    queue_item(make_insert(0, -4096, 0));
    queue_item(make_insert(0, 0, 4096));
    queue_item(make_query(7));
    queue_item(make_query(511));
    queue_item(make_insert(1, 1, 1));
    queue_item(make_query(1));
    // Fill the store, overflow it, then drain it whole
    repeat (dqk_pkg::CAPACITY + 2)
      queue_item(make_insert($urandom, $urandom, $urandom));
    queue_item(make_query(257));
    queue_item(make_query(256));
    // Random part
    calm_stretch = 1'b0;
    for (n = 0; n < 130; n++) begin
      if (n >= 40 && n < 100) calm_stretch = 1'b1;
      else calm_stretch = 1'b0;
      if ($urandom_range(99) < 65) begin
        if ($urandom_range(3) == 0)
          queue_item(make_insert($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                                 $urandom_range(8191) - 4096));
        else
          queue_item(make_insert($urandom, $urandom, $urandom));
      end else begin
        case ($urandom_range(9))
          0: k = 0;
          1: k = model_depth + 1 + $urandom_range(511 - model_depth - 1 < 0 ? 0 : 10);
          2: k = $urandom_range(511);
          default: k = (model_depth == 0) ? 1 : $urandom_range(1, model_depth > 8 ? 8 : model_depth);
        endcase
        queue_item(make_query(k));
      end
      while (pending_items.size() > 8) @(posedge clk);
    end
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("distance_queue_kmin_average_top: match");
    end else begin
      $display("distance_queue_kmin_average_top: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #60ms;
    $display("distance_queue_kmin_average_top: mismatch");
    $finish;
  end

endmodule
